FILE: rtl/lss_pkg.sv
// Shared constants, widths and controller/datapath handshake types for the
// least-squares slope block. No dependencies.
`default_nettype none

package lss_pkg;

    // Capacity in sample pairs per set.
    localparam int MAX_SAMPLES = 1024;

    localparam int SMP_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int SLOPE_W = 32;
    localparam int LOG_MAX = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int PRD_W   = 2 * SMP_W;
    localparam int SX_W    = SMP_W + LOG_MAX + 1;
    localparam int SXY_W   = PRD_W + LOG_MAX;
    localparam int SXX_W   = PRD_W + LOG_MAX - 1;
    // Holds n*Sxy, Sx*Sy and their difference with one bit to spare.
    localparam int NUM_W   = CNT_W + SXY_W + 2;
    localparam int DVD_W   = NUM_W + FRAC_W;
    localparam int ITER_W  = $clog2(DVD_W);
    localparam int QUO_W   = SLOPE_W + 1;

    localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_SAMPLES);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DVD_W - 1);

    localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = {1'b1, {(SLOPE_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic mul1;
        logic mul2;
        logic den;
        logic div_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_last;
        logic den_zero;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/lss_if.sv
// Sample and result channel interfaces of the least-squares slope block.
// Depends on lss_pkg for field widths.
`default_nettype none

interface lss_in_if import lss_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] x_sample;
    logic signed [SMP_W-1:0] y_sample;
    logic                    last;

    modport source (output valid, x_sample, y_sample, last, input ready);
    modport sink   (input valid, x_sample, y_sample, last, output ready);
endinterface

interface lss_out_if import lss_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SLOPE_W-1:0] slope_value;
    logic [CNT_W-1:0]          sample_count;
    logic                      degenerate;
    logic                      saturated;
    logic                      dropped;

    modport source (output valid, slope_value, sample_count, degenerate, saturated, dropped,
                    input ready);
    modport sink   (input valid, slope_value, sample_count, degenerate, saturated, dropped,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/lss_ctrl.sv
// Sequencing controller of the least-squares slope block.
// Depends on lss_pkg for command and status types.
`default_nettype none

module lss_ctrl import lss_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_DEN   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        unique case (r_state)
            S_ACC: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.acc_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_MUL1;
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DEN;
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_iter    = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_sts.den_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (r_iter == ITER_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_iter = r_iter + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lss_dp.sv
// Datapath of the least-squares slope block: accumulators, numerator and
// denominator multipliers, restoring divider and result register.
// Depends on lss_pkg and the channel interfaces in lss_if.
`default_nettype none

module lss_dp import lss_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    lss_in_if.sink      i_smp,
    lss_out_if.source   o_res
);

    // Running sums.
    logic [CNT_W-1:0]        r_count;
    logic                    r_drop;
    logic signed [SX_W-1:0]  r_sx;
    logic signed [SX_W-1:0]  r_sy;
    logic signed [SXY_W-1:0] r_sxy;
    logic signed [SXX_W-1:0] r_sxx;

    // Product stage between the input and the accumulators.
    logic                    r_st_add;
    logic signed [SMP_W-1:0] r_st_x;
    logic signed [SMP_W-1:0] r_st_y;
    logic signed [PRD_W-1:0] r_pxy;
    logic signed [PRD_W-1:0] r_pxx;

    // Final computation.
    logic signed [CNT_W+SXY_W:0] r_m1;
    logic signed [2*SX_W-1:0]    r_m2;
    logic signed [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]            r_den;
    logic                        r_neg;
    logic [DVD_W-1:0]            r_dvd;
    logic [NUM_W-1:0]            r_rem;
    logic [QUO_W-1:0]            r_quo;
    logic                        r_qovf;
    logic [CNT_W-1:0]            r_hold_cnt;
    logic                        r_hold_drop;

    // Result register.
    logic                      r_o_valid;
    logic signed [SLOPE_W-1:0] r_o_slope;
    logic [CNT_W-1:0]          r_o_cnt;
    logic                      r_o_degen;
    logic                      r_o_sat;
    logic                      r_o_drop;

    logic                        w_acc;
    logic                        w_room;
    logic signed [PRD_W-1:0]     w_pxy;
    logic signed [PRD_W-1:0]     w_pxx;
    logic signed [CNT_W:0]       w_m1_a;
    logic signed [SXY_W-1:0]     w_m1_b;
    logic signed [SX_W-1:0]      w_m2_b;
    logic signed [CNT_W+SXY_W:0] w_m1;
    logic signed [2*SX_W-1:0]    w_m2;
    logic signed [NUM_W-1:0]     w_diff;
    logic [NUM_W-1:0]            w_mag;
    logic [NUM_W:0]              w_trial;
    logic                        w_ge;
    logic                        w_big;
    logic [SLOPE_W-1:0]          w_qlow;
    logic [SLOPE_W-1:0]          w_slope;
    logic                        w_sat;

    assign i_smp.ready = i_cmd.in_ready;
    assign w_acc       = i_smp.valid && i_cmd.in_ready;
    assign w_room      = (r_count != MAX_COUNT);
    assign w_pxy       = i_smp.x_sample * i_smp.y_sample;
    assign w_pxx       = i_smp.x_sample * i_smp.x_sample;

    assign o_sts.acc_last = w_acc && i_smp.last;
    assign o_sts.den_zero = (r_den == '0);
    assign o_sts.out_free = !r_o_valid || o_res.ready;

    // Shared multipliers: n*Sxy and Sx*Sy first, then n*Sxx and Sx*Sx.
    assign w_m1_a = $signed({1'b0, r_count});
    assign w_m1_b = i_cmd.mul1 ? r_sxy : {{(SXY_W-SXX_W){r_sxx[SXX_W-1]}}, r_sxx};
    assign w_m2_b = i_cmd.mul1 ? r_sy : r_sx;
    assign w_m1   = w_m1_a * w_m1_b;
    assign w_m2   = r_sx * w_m2_b;
    assign w_diff = NUM_W'(r_m1) - NUM_W'(r_m2);
    assign w_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    // One restoring division step per cycle.
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Clamp the scaled quotient into the signed result range.
    assign w_big  = r_qovf || r_quo[QUO_W-1];
    assign w_qlow = r_quo[SLOPE_W-1:0];
    always_comb begin
        w_sat   = 1'b0;
        w_slope = '0;
        if (!o_sts.den_zero) begin
            if (r_neg) begin
                w_sat   = w_big || (w_qlow > SLOPE_NEG_MAX);
                w_slope = w_sat ? SLOPE_NEG_MAX : SLOPE_W'(-w_qlow);
            end else begin
                w_sat   = w_big || w_qlow[SLOPE_W-1];
                w_slope = w_sat ? SLOPE_POS_MAX : w_qlow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxy    <= '0;
            r_sxx    <= '0;
            r_st_add <= 1'b0;
        end else begin
            r_st_add <= w_acc && w_room;
            if (w_acc) begin
                if (w_room) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (r_st_add) begin
                r_sx  <= r_sx + SX_W'(r_st_x);
                r_sy  <= r_sy + SX_W'(r_st_y);
                r_sxy <= r_sxy + SXY_W'(r_pxy);
                r_sxx <= r_sxx + SXX_W'(r_pxx);
            end
            if (i_cmd.den) begin
                r_count <= '0;
                r_drop  <= 1'b0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sxy   <= '0;
                r_sxx   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st_x <= i_smp.x_sample;
        r_st_y <= i_smp.y_sample;
        r_pxy  <= w_pxy;
        r_pxx  <= w_pxx;
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_m1 <= w_m1;
            r_m2 <= w_m2;
        end
        if (i_cmd.mul2) begin
            r_num <= w_diff;
        end
        if (i_cmd.den) begin
            r_den       <= w_diff;
            r_neg       <= r_num[NUM_W-1];
            r_dvd       <= {w_mag, {FRAC_W{1'b0}}};
            r_rem       <= '0;
            r_quo       <= '0;
            r_qovf      <= 1'b0;
            r_hold_cnt  <= r_count;
            r_hold_drop <= r_drop;
        end
        if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem  <= w_ge ? NUM_W'(w_trial - {1'b0, r_den}) : w_trial[NUM_W-1:0];
            r_quo  <= {r_quo[QUO_W-2:0], w_ge};
            r_qovf <= r_qovf || r_quo[QUO_W-1];
        end
        if (i_cmd.load_out) begin
            r_o_slope <= w_slope;
            r_o_cnt   <= r_hold_cnt;
            r_o_degen <= o_sts.den_zero;
            r_o_sat   <= w_sat;
            r_o_drop  <= r_hold_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.slope_value  = r_o_slope;
    assign o_res.sample_count = r_o_cnt;
    assign o_res.degenerate   = r_o_degen;
    assign o_res.saturated    = r_o_sat;
    assign o_res.dropped      = r_o_drop;

endmodule

`default_nettype wire

FILE: rtl/least_squares_slope_top.sv
// Least-squares slope: accepts one sample word per cycle while accumulating a set.
// After the word marked last, intake pauses until the result is loaded: through
// the drain, multiply and denominator steps, then the one-bit-per-cycle divider
// over the 71-bit scaled numerator, skipped if the denominator is zero. The result
// word waits in its own register, so intake resumes even before the sink takes it.
// Synchronous active-low reset clears sums, count, drop flag, sequencer and valids.
`default_nettype none

module least_squares_slope_top import lss_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    lss_in_if.sink    i_smp,
    lss_out_if.source o_res
);

    // The controller walks through accumulate, drain, two multiply steps,
    // the denominator step, the division loop and the result load. The
    // datapath holds all sums, products and the divider, and only talks to
    // the controller through the command and status structs below.
    t_cmd w_cmd;
    t_sts w_sts;

    lss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Each accepted pair is multiplied in the accept cycle and added into the
    // sums in the next cycle; the drain state covers that stage for the last word.
    lss_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_smp   (i_smp),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

FILE: verif/tb_least_squares_slope_top.sv
// Self-checking testbench for least_squares_slope_top: drives sample words, predicts each
// slope result and checks every result word field by field.
// Depends on lss_pkg, lss_in_if and lss_out_if from the rtl folder.
`default_nettype none

module tb_least_squares_slope_top;
    import lss_pkg::*;

    // The longest correct quiet stretch is the long sink hold-off plus one division.
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int PHASE_WORDS      = 40;
    localparam int DIR_ROWS         = 22;
    localparam int MAX_PRINTED      = 100;

    // One result word as the block reports it.
    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic [CNT_W-1:0]          count;
        logic                      degen;
        logic                      sat;
        logic                      drop;
    } slope_res_t;

    // One row of the directed table. When typed is set, the row's own expected
    // result is used instead of the predicted one.
    typedef struct packed {
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] y;
        logic                    last;
        logic                    typed;
        logic [SLOPE_W-1:0]      slope;
        logic [CNT_W-1:0]        count;
        logic                    degen;
        logic                    sat;
    } dir_row_t;

    // Shapes of random sample sets.
    typedef enum int {
        SET_FULL,    // full-range samples, extremes favored
        SET_NARROW,  // small values, exact slopes that are easy to follow
        SET_FLAT_X,  // constant x, so the denominator is zero
        SET_STEEP    // x spread of one step against full-range y, often saturates
    } set_kind_e;

    logic i_clk;
    logic i_rst_n;

    lss_in_if  smp_if ();
    lss_out_if res_if ();

    least_squares_slope_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle percentages of both sides and the request for a long sink hold-off.
    int src_idle_pct  = 27;
    int sink_idle_pct = 66;
    bit hold_req      = 1'b0;

    // Directed expectations travel alongside the sample word they belong to.
    logic       row_typed;
    slope_res_t row_exp;

    slope_res_t slope_expq[$];
    int         err_count = 0;

    // Accumulator copy of the predictor.
    int     acc_count   = 0;
    longint acc_sx      = 0;
    longint acc_sy      = 0;
    longint acc_sxy     = 0;
    longint acc_sxx     = 0;
    bit     acc_dropped = 1'b0;

    dir_row_t dir_rows [DIR_ROWS];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < MAX_PRINTED)
            $display("mismatch %s: got %0d, want %0d", what, got, want);
        err_count++;
    endtask

    // Accumulates one pair and, on the last pair of a set, forms the slope result
    // and clears the sums. Returns 1 when a result word is due.
    function automatic bit predict_slope(input logic signed [SMP_W-1:0] x,
                                         input logic signed [SMP_W-1:0] y,
                                         input logic last,
                                         output slope_res_t res);
        longint       xs, ys, n, num, den;
        logic [127:0] quo;
        bit           neg;
        xs  = x;
        ys  = y;
        res = '0;
        // A pair arriving at full capacity is ignored, the last one included.
        if (acc_count < MAX_SAMPLES) begin
            acc_count++;
            acc_sx  += xs;
            acc_sy  += ys;
            acc_sxy += xs * ys;
            acc_sxx += xs * xs;
        end else begin
            acc_dropped = 1'b1;
        end
        if (!last)
            return 1'b0;

        n   = acc_count;
        num = n * acc_sxy - acc_sx * acc_sy;
        den = n * acc_sxx - acc_sx * acc_sx;
        res.count = CNT_W'(acc_count);
        res.drop  = acc_dropped;
        if (den == 0) begin
            // One point or constant x: no slope at all.
            res.degen = 1'b1;
        end else begin
            neg = (num < 0);
            quo = (128'(neg ? -num : num) << FRAC_W) / 128'(den);
            if (neg) begin
                if (quo > 128'h8000_0000) begin
                    res.slope = SLOPE_NEG_MAX;
                    res.sat   = 1'b1;
                end else begin
                    res.slope = SLOPE_W'(-quo);
                end
            end else begin
                if (quo > 128'h7FFF_FFFF) begin
                    res.slope = SLOPE_POS_MAX;
                    res.sat   = 1'b1;
                end else begin
                    res.slope = SLOPE_W'(quo);
                end
            end
        end
        acc_count   = 0;
        acc_sx      = 0;
        acc_sy      = 0;
        acc_sxy     = 0;
        acc_sxx     = 0;
        acc_dropped = 1'b0;
        return 1'b1;
    endfunction

    // Offers one sample word after a random number of idle cycles and returns at
    // the rising edge that accepts it. Valid stays high until the next call or
    // until idle_input lowers it.
    task automatic send_word(input logic signed [SMP_W-1:0] x, input logic signed [SMP_W-1:0] y,
                             input logic last, input logic typed, input slope_res_t exp_word);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid    <= 1'b1;
        smp_if.x_sample <= x;
        smp_if.y_sample <= y;
        smp_if.last     <= last;
        row_typed       <= typed;
        row_exp         <= exp_word;
        @(posedge i_clk);
        while (!smp_if.ready)
            @(posedge i_clk);
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (slope_expq.size() != 0)
            @(posedge i_clk);
    endtask

    // Sends one set of len pairs of the given shape, the final pair marked last.
    task automatic send_random_set(input int len, input set_kind_e kind);
        logic signed [SMP_W-1:0] x, y, x0;
        int i;
        x0 = SMP_W'($urandom);
        for (i = 0; i < len; i++) begin
            case (kind)
                SET_FULL: begin
                    x = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'sh7FFF : 16'sh8000)
                                                 : SMP_W'($urandom);
                    y = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'sh7FFF : 16'sh8000)
                                                 : SMP_W'($urandom);
                end
                SET_NARROW: begin
                    x = SMP_W'(int'($urandom_range(16)) - 8);
                    y = SMP_W'(int'($urandom_range(16)) - 8);
                end
                SET_FLAT_X: begin
                    x = x0;
                    y = SMP_W'($urandom);
                end
                default: begin
                    x = x0 ^ SMP_W'($urandom_range(1));
                    y = SMP_W'($urandom);
                end
            endcase
            send_word(x, y, (i == len - 1), 1'b0, '0);
        end
    endtask

    // Result sink: random ready, or a long hold-off when the stimulus asks for one,
    // so that the result register stays full and the block stops taking samples.
    initial begin : result_sink
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Scoreboard: results are checked before the same edge's sample word is
    // predicted, since a result can never stem from a word taken at the same edge.
    always @(posedge i_clk) begin : scoreboard
        slope_res_t got, want, pred;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.slope = res_if.slope_value;
                got.count = res_if.sample_count;
                got.degen = res_if.degenerate;
                got.sat   = res_if.saturated;
                got.drop  = res_if.dropped;
                if (slope_expq.size() == 0) begin
                    report_mismatch("result word with none expected, slope",
                                    longint'($signed(got.slope)), 0);
                end else begin
                    want = slope_expq.pop_front();
                    if (got.slope !== want.slope)
                        report_mismatch("slope_value", longint'($signed(got.slope)),
                                        longint'($signed(want.slope)));
                    if (got.count !== want.count)
                        report_mismatch("sample_count", got.count, want.count);
                    if (got.degen !== want.degen)
                        report_mismatch("degenerate", got.degen, want.degen);
                    if (got.sat !== want.sat)
                        report_mismatch("saturated", got.sat, want.sat);
                    if (got.drop !== want.drop)
                        report_mismatch("dropped", got.drop, want.drop);
                end
            end
            if (smp_if.valid && smp_if.ready) begin
                if (predict_slope(smp_if.x_sample, smp_if.y_sample, smp_if.last, pred))
                    slope_expq.push_back(row_typed ? row_exp : pred);
            end
        end
    end

    // Ends the run when no word moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int         i, phase, phase_words, len;
        dir_row_t   row;
        slope_res_t exp_word;

        i_rst_n         = 1'b0;
        smp_if.valid    = 1'b0;
        smp_if.x_sample = '0;
        smp_if.y_sample = '0;
        smp_if.last     = 1'b0;
        row_typed       = 1'b0;
        row_exp         = '0;

        // Fields: x, y, last, typed, slope, count, degenerate, saturated.
        dir_rows = '{
            // A single point has no slope.
            '{16'sd5,      -16'sd7,     1'b1, 1'b1, 32'h0000_0000, 11'd2 - 11'd1, 1'b1, 1'b0},
            // Both extremes on the diagonal give a slope of exactly one.
            '{16'sh8000,   16'sh8000,   1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sh7FFF,   16'sh7FFF,   1'b1, 1'b1, 32'h0001_0000, 11'd2, 1'b0, 1'b0},
            // A rise of 65535 over one step saturates high.
            '{16'sd0,      16'sh8000,   1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd1,      16'sh7FFF,   1'b1, 1'b1, 32'h7FFF_FFFF, 11'd2, 1'b0, 1'b1},
            // The same fall saturates low.
            '{16'sd0,      16'sh7FFF,   1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd1,      16'sh8000,   1'b1, 1'b1, 32'h8000_0000, 11'd2, 1'b0, 1'b1},
            // A slope of -32768 lands on the most negative value without clamping.
            '{16'sd0,      16'sd0,      1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd1,      16'sh8000,   1'b1, 1'b1, 32'h8000_0000, 11'd2, 1'b0, 1'b0},
            // A slope of +32768 is one past the top and clamps.
            '{16'sd0,      16'sh8000,   1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd1,      16'sd0,      1'b1, 1'b1, 32'h7FFF_FFFF, 11'd2, 1'b0, 1'b1},
            // A slope of +32767 is the largest that fits.
            '{16'sd0,      16'sd0,      1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd1,      16'sh7FFF,   1'b1, 1'b1, 32'h7FFF_0000, 11'd2, 1'b0, 1'b0},
            // Constant x makes the denominator zero.
            '{16'sd100,    16'sd1,      1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd100,    -16'sd5,     1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd100,    16'sd9,      1'b1, 1'b1, 32'h0000_0000, 11'd3, 1'b1, 1'b0},
            // A mixed set left to the predictor.
            '{-16'sd3,     16'sd4,      1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd2,      -16'sd1,     1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd7,      16'sd11,     1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sh7FFF,   16'sh8000,   1'b1, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            // All-zero pairs.
            '{16'sd0,      16'sd0,      1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
            '{16'sd0,      16'sd0,      1'b1, 1'b1, 32'h0000_0000, 11'd2, 1'b1, 1'b0}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (i = 0; i < DIR_ROWS; i++) begin
            row      = dir_rows[i];
            exp_word = '{row.slope, row.count, row.degen, row.sat, 1'b0};
            send_word(row.x, row.y, row.last, row.typed, exp_word);
        end
        idle_input();
        wait_results_drained();

        // Back pressure: the sink holds off while short sets keep coming, so the
        // result register fills and the block must stall its sample input.
        hold_req = 1'b1;
        repeat (4) send_random_set(2, SET_FULL);
        idle_input();
        wait_results_drained();

        // Random sets under three idling patterns. The sender pauses after each
        // pattern until every expected result has come back.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 27;
                    sink_idle_pct = 66;
                end
                1: begin
                    src_idle_pct  = 66;
                    sink_idle_pct = 27;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(150, 13) : $urandom_range(12, 1);
                send_random_set(len, set_kind_e'($urandom_range(3)));
                phase_words += len;
            end
            if (phase == 2) begin
                // A set whose first pairs fill the capacity exactly and whose last
                // pair arrives past it and is dropped.
                send_random_set(MAX_SAMPLES + 1, SET_FULL);
            end
            idle_input();
            wait_results_drained();
        end

        repeat (100) @(posedge i_clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
